@@ rtl/epc_pkg.sv @@
// Shared constants, command and region codes, and result type for the eye pixel compositor.
package epc_pkg;

	// Geometry of the screen, the sclera image, the iris window and the iris texture
	localparam int SCREEN_SIDE    = 128;
	localparam int SCLERA_SIDE    = 256;
	localparam int IRIS_SIDE      = 128;
	localparam int TEXTURE_WIDTH  = 512;
	localparam int TEXTURE_HEIGHT = 64;

	localparam int LID_DEPTH    = SCREEN_SIDE * SCREEN_SIDE;
	localparam int SCLERA_DEPTH = SCLERA_SIDE * SCLERA_SIDE;
	localparam int POLAR_DEPTH  = IRIS_SIDE * IRIS_SIDE;
	localparam int TEX_DEPTH    = TEXTURE_WIDTH * TEXTURE_HEIGHT;
	localparam int IRIS_MARGIN  = (SCLERA_SIDE - IRIS_SIDE) / 2;

	localparam int LID_AW    = $clog2(LID_DEPTH);
	localparam int SCLERA_AW = $clog2(SCLERA_DEPTH);
	localparam int POLAR_AW  = $clog2(POLAR_DEPTH);
	localparam int TEX_AW    = $clog2(TEX_DEPTH);

	// Field widths
	localparam int CMD_W     = 3;
	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 16;
	localparam int PIX_W     = 7;
	localparam int SCALE_W   = 10;
	localparam int OFS_W     = 8;
	localparam int LID_W     = 8;
	localparam int COLOR_W   = 16;
	localparam int REGION_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = SCALE_W;

	// Sum of an offset and a screen position
	localparam int POS_W = OFS_W + 1;

	// Polar entry: low bits distance, high bits angle
	localparam int DIST_W      = 7;
	localparam int ANGLE_W     = DATA_W - DIST_W;
	localparam int ANGLE_RANGE = 512;
	localparam int SCALE_SHIFT = 7;
	localparam int PROD_W      = SCALE_W + DIST_W;
	localparam int RADIUS_W    = PROD_W - SCALE_SHIFT;

	// Output queue
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	// Commands
	localparam logic [CMD_W-1:0] CMD_UPPER_LID = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOWER_LID = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SCLERA    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POLAR     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TEXTURE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RENDER    = 3'd5;

	// Regions
	localparam logic [REGION_W-1:0] REGION_LID    = 2'd0;
	localparam logic [REGION_W-1:0] REGION_SCLERA = 2'd1;
	localparam logic [REGION_W-1:0] REGION_IRIS   = 2'd2;
	localparam logic [REGION_W-1:0] REGION_BEYOND = 2'd3;

	// Configuration register indices
	localparam logic [CFG_IDX_W-1:0] CFG_IRIS_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCLERA_X   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCLERA_Y   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_TH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TH   = 3'd4;

	// Configuration reset values
	localparam logic [SCALE_W-1:0] RST_IRIS_SCALE = 10'd512;
	localparam logic [OFS_W-1:0]   RST_SCLERA_X   = 8'd64;
	localparam logic [OFS_W-1:0]   RST_SCLERA_Y   = 8'd64;
	localparam logic [LID_W-1:0]   RST_UPPER_TH   = 8'd128;
	localparam logic [LID_W-1:0]   RST_LOWER_TH   = 8'd126;

	typedef struct packed {
		logic [COLOR_W-1:0]  color;
		logic [REGION_W-1:0] region;
	} pixel_t;

endpackage

@@ rtl/epc_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module epc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/epc_out_fifo.sv @@
// Output queue holding finished pixels until the downstream side takes them.
module epc_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  epc_pkg::pixel_t push_item,
	input  logic            pop,
	output logic            not_empty,
	output epc_pkg::pixel_t head
);

	epc_pkg::pixel_t                   mem_q [epc_pkg::OUT_DEPTH];
	logic [epc_pkg::OUT_AW-1:0]        wr_ptr_q;
	logic [epc_pkg::OUT_AW-1:0]        rd_ptr_q;
	logic [epc_pkg::CNT_W-1:0]         fill_q;

	// Store pushed pixels
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

@@ rtl/eye_pixel_compositor.sv @@
// Top level of the eye pixel compositor: table memories, render pipeline and output queue.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | command, table_address, table_data, pixel_x/y
//   out     | out_valid/out_ready  | color, region
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One input transaction per cycle while in_ready is high. A render result passes the
// lid/polar/sclera read, the iris scale multiply and the texture read before it is
// pushed into the output queue. Loads retire on acceptance; texture loads pass the stage 1
// and stage 2 registers and are written at the texture port, in order with texture reads.
// in_ready drops while eight renders are in flight or queued. cfg_ready is always high.
// Reset clears the pipeline and queue and loads the register defaults; tables are not cleared.
module eye_pixel_compositor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [epc_pkg::CMD_W-1:0]       command,
	input  logic [epc_pkg::ADDR_W-1:0]      table_address,
	input  logic [epc_pkg::DATA_W-1:0]      table_data,
	input  logic [epc_pkg::PIX_W-1:0]       pixel_x,
	input  logic [epc_pkg::PIX_W-1:0]       pixel_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [epc_pkg::COLOR_W-1:0]     color,
	output logic [epc_pkg::REGION_W-1:0]    region,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [epc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [epc_pkg::CFG_W-1:0]       cfg_data
);

	// Configuration registers
	logic [epc_pkg::SCALE_W-1:0] iris_scale_q;
	logic [epc_pkg::OFS_W-1:0]   sclera_x_q;
	logic [epc_pkg::OFS_W-1:0]   sclera_y_q;
	logic [epc_pkg::LID_W-1:0]   upper_th_q;
	logic [epc_pkg::LID_W-1:0]   lower_th_q;

	// Handshakes
	logic in_acc;
	logic render_acc;
	logic out_pop;

	// Accept-stage addresses
	logic [31:0]                   lid_sum;
	logic [31:0]                   sclera_sum;
	logic [31:0]                   polar_sum;
	logic [epc_pkg::POS_W-1:0]     sx;
	logic [epc_pkg::POS_W-1:0]     sy;
	logic                          in_window;
	logic [epc_pkg::LID_AW-1:0]    lid_raddr;
	logic [epc_pkg::SCLERA_AW-1:0] sclera_raddr;
	logic [epc_pkg::POLAR_AW-1:0]  polar_raddr;

	// Write enables
	logic upper_we;
	logic lower_we;
	logic sclera_we;
	logic polar_we;
	logic tex_load;

	// Memory read data
	logic [epc_pkg::LID_W-1:0]   upper_rd;
	logic [epc_pkg::LID_W-1:0]   lower_rd;
	logic [epc_pkg::COLOR_W-1:0] sclera_rd;
	logic [epc_pkg::DATA_W-1:0]  polar_rd;
	logic [epc_pkg::COLOR_W-1:0] tex_rd;

	// Stage 1
	logic                         v_s1;
	logic                         win_s1;
	logic                         tex_we_s1;
	logic [epc_pkg::TEX_AW-1:0]   tex_waddr_s1;
	logic [epc_pkg::DATA_W-1:0]   tex_wdata_s1;
	logic                         covered;
	logic [epc_pkg::PROD_W-1:0]   prod;

	// Stage 2
	logic                         v_s2;
	logic                         win_s2;
	logic                         covered_s2;
	logic [epc_pkg::PROD_W-1:0]   prod_s2;
	logic [epc_pkg::ANGLE_W-1:0]  angle_s2;
	logic [epc_pkg::COLOR_W-1:0]  sclera_s2;
	logic                         tex_we_s2;
	logic [epc_pkg::TEX_AW-1:0]   tex_waddr_s2;
	logic [epc_pkg::DATA_W-1:0]   tex_wdata_s2;
	logic [epc_pkg::RADIUS_W-1:0] radius;
	logic [31:0]                  angle_col;
	logic [31:0]                  tex_sum;
	logic [epc_pkg::TEX_AW-1:0]   tex_raddr;
	logic [epc_pkg::REGION_W-1:0] region_s2c;

	// Stage 3
	logic                          v_s3;
	logic [epc_pkg::REGION_W-1:0]  region_s3;
	logic [epc_pkg::COLOR_W-1:0]   sclera_s3;
	epc_pkg::pixel_t               pix_s3;
	epc_pkg::pixel_t               head;

	// Renders in flight or queued
	logic [epc_pkg::CNT_W-1:0] credit_q;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iris_scale_q <= epc_pkg::RST_IRIS_SCALE;
			sclera_x_q   <= epc_pkg::RST_SCLERA_X;
			sclera_y_q   <= epc_pkg::RST_SCLERA_Y;
			upper_th_q   <= epc_pkg::RST_UPPER_TH;
			lower_th_q   <= epc_pkg::RST_LOWER_TH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				epc_pkg::CFG_IRIS_SCALE: iris_scale_q <= cfg_data;
				epc_pkg::CFG_SCLERA_X:   sclera_x_q   <= cfg_data[epc_pkg::OFS_W-1:0];
				epc_pkg::CFG_SCLERA_Y:   sclera_y_q   <= cfg_data[epc_pkg::OFS_W-1:0];
				epc_pkg::CFG_UPPER_TH:   upper_th_q   <= cfg_data[epc_pkg::LID_W-1:0];
				epc_pkg::CFG_LOWER_TH:   lower_th_q   <= cfg_data[epc_pkg::LID_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept when the output queue has room for every render in flight
	assign in_ready   = (credit_q < epc_pkg::CNT_W'(epc_pkg::OUT_DEPTH));
	assign in_acc     = in_valid && in_ready;
	assign render_acc = in_acc && (command == epc_pkg::CMD_RENDER);
	assign out_pop    = out_valid && out_ready;

	// Decode loads, dropping addresses beyond each table
	always_comb begin
		upper_we  = 1'b0;
		lower_we  = 1'b0;
		sclera_we = 1'b0;
		polar_we  = 1'b0;
		tex_load  = 1'b0;
		if (in_acc) begin
			unique case (command)
				epc_pkg::CMD_UPPER_LID:
					upper_we = (32'(table_address) < epc_pkg::LID_DEPTH);
				epc_pkg::CMD_LOWER_LID:
					lower_we = (32'(table_address) < epc_pkg::LID_DEPTH);
				epc_pkg::CMD_SCLERA:
					sclera_we = (32'(table_address) < epc_pkg::SCLERA_DEPTH);
				epc_pkg::CMD_POLAR:
					polar_we = (32'(table_address) < epc_pkg::POLAR_DEPTH);
				epc_pkg::CMD_TEXTURE:
					tex_load = (32'(table_address) < epc_pkg::TEX_DEPTH);
				default: ;
			endcase
		end
	end

	// Form read addresses from the screen position
	always_comb begin
		sx         = epc_pkg::POS_W'(sclera_x_q) + epc_pkg::POS_W'(pixel_x);
		sy         = epc_pkg::POS_W'(sclera_y_q) + epc_pkg::POS_W'(pixel_y);
		lid_sum    = 32'(pixel_y) * epc_pkg::SCREEN_SIDE + 32'(pixel_x);
		sclera_sum = (32'(sy) % epc_pkg::SCLERA_SIDE) * epc_pkg::SCLERA_SIDE
			+ (32'(sx) % epc_pkg::SCLERA_SIDE);
		polar_sum  = (32'(sy) - epc_pkg::IRIS_MARGIN) * epc_pkg::IRIS_SIDE
			+ (32'(sx) - epc_pkg::IRIS_MARGIN);
		in_window  = (32'(sx) >= epc_pkg::IRIS_MARGIN)
			&& (32'(sx) < epc_pkg::IRIS_MARGIN + epc_pkg::IRIS_SIDE)
			&& (32'(sy) >= epc_pkg::IRIS_MARGIN)
			&& (32'(sy) < epc_pkg::IRIS_MARGIN + epc_pkg::IRIS_SIDE);
		lid_raddr    = lid_sum[epc_pkg::LID_AW-1:0];
		sclera_raddr = sclera_sum[epc_pkg::SCLERA_AW-1:0];
		polar_raddr  = polar_sum[epc_pkg::POLAR_AW-1:0];
	end

	epc_ram #(.WIDTH(epc_pkg::LID_W), .DEPTH(epc_pkg::LID_DEPTH)) u_upper_lid (
		.clk   (clk),
		.we    (upper_we),
		.waddr (table_address[epc_pkg::LID_AW-1:0]),
		.wdata (table_data[epc_pkg::LID_W-1:0]),
		.raddr (lid_raddr),
		.rdata (upper_rd)
	);

	epc_ram #(.WIDTH(epc_pkg::LID_W), .DEPTH(epc_pkg::LID_DEPTH)) u_lower_lid (
		.clk   (clk),
		.we    (lower_we),
		.waddr (table_address[epc_pkg::LID_AW-1:0]),
		.wdata (table_data[epc_pkg::LID_W-1:0]),
		.raddr (lid_raddr),
		.rdata (lower_rd)
	);

	epc_ram #(.WIDTH(epc_pkg::COLOR_W), .DEPTH(epc_pkg::SCLERA_DEPTH)) u_sclera (
		.clk   (clk),
		.we    (sclera_we),
		.waddr (table_address[epc_pkg::SCLERA_AW-1:0]),
		.wdata (table_data),
		.raddr (sclera_raddr),
		.rdata (sclera_rd)
	);

	epc_ram #(.WIDTH(epc_pkg::DATA_W), .DEPTH(epc_pkg::POLAR_DEPTH)) u_polar (
		.clk   (clk),
		.we    (polar_we),
		.waddr (table_address[epc_pkg::POLAR_AW-1:0]),
		.wdata (table_data),
		.raddr (polar_raddr),
		.rdata (polar_rd)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			tex_we_s1 <= 1'b0;
		end else begin
			v_s1      <= render_acc;
			tex_we_s1 <= tex_load;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		win_s1       <= in_window;
		tex_waddr_s1 <= table_address[epc_pkg::TEX_AW-1:0];
		tex_wdata_s1 <= table_data;
	end

	// Test the lids and scale the polar distance
	assign covered = (lower_rd <= lower_th_q) || (upper_rd <= upper_th_q);
	assign prod    = epc_pkg::PROD_W'(iris_scale_q)
		* epc_pkg::PROD_W'(polar_rd[epc_pkg::DIST_W-1:0]);

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			tex_we_s2 <= 1'b0;
		end else begin
			v_s2      <= v_s1;
			tex_we_s2 <= tex_we_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		win_s2       <= win_s1;
		covered_s2   <= covered;
		prod_s2      <= prod;
		angle_s2     <= polar_rd[epc_pkg::DATA_W-1:epc_pkg::DIST_W];
		sclera_s2    <= sclera_rd;
		tex_waddr_s2 <= tex_waddr_s1;
		tex_wdata_s2 <= tex_wdata_s1;
	end

	// Texture address and region choice
	always_comb begin
		radius    = prod_s2[epc_pkg::PROD_W-1:epc_pkg::SCALE_SHIFT];
		angle_col = (32'(angle_s2) * epc_pkg::TEXTURE_WIDTH) / epc_pkg::ANGLE_RANGE;
		tex_sum   = 32'(radius) * epc_pkg::TEXTURE_WIDTH + angle_col;
		tex_raddr = tex_sum[epc_pkg::TEX_AW-1:0];
		priority if (covered_s2) begin
			region_s2c = epc_pkg::REGION_LID;
		end else if (!win_s2) begin
			region_s2c = epc_pkg::REGION_SCLERA;
		end else if (32'(radius) < epc_pkg::TEXTURE_HEIGHT) begin
			region_s2c = epc_pkg::REGION_IRIS;
		end else begin
			region_s2c = epc_pkg::REGION_BEYOND;
		end
	end

	// Texture loads land here so they stay in order with texture reads
	epc_ram #(.WIDTH(epc_pkg::COLOR_W), .DEPTH(epc_pkg::TEX_DEPTH)) u_texture (
		.clk   (clk),
		.we    (tex_we_s2),
		.waddr (tex_waddr_s2),
		.wdata (tex_wdata_s2),
		.raddr (tex_raddr),
		.rdata (tex_rd)
	);

	// Stage 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	// Stage 3 payload
	always_ff @(posedge clk) begin
		region_s3 <= region_s2c;
		sclera_s3 <= sclera_s2;
	end

	// Select the pixel colour
	always_comb begin
		pix_s3.region = region_s3;
		unique case (region_s3)
			epc_pkg::REGION_LID:    pix_s3.color = '0;
			epc_pkg::REGION_IRIS:   pix_s3.color = tex_rd;
			epc_pkg::REGION_SCLERA: pix_s3.color = sclera_s3;
			epc_pkg::REGION_BEYOND: pix_s3.color = sclera_s3;
			default:                pix_s3.color = sclera_s3;
		endcase
	end

	epc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_item (pix_s3),
		.pop       (out_pop),
		.not_empty (out_valid),
		.head      (head)
	);

	assign color  = head.color;
	assign region = head.region;

	// Count renders between acceptance and output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (render_acc && !out_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_pop && !render_acc) begin
			credit_q <= credit_q - 1'b1;
		end
	end

endmodule

@@ verif/eye_pixel_compositor_tb.sv @@
// Self-checking testbench for the eye pixel compositor: table loads, renders and register writes.
module eye_pixel_compositor_tb;
	import epc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	// Codes the block must ignore
	localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic [PIX_W-1:0]  x;
		logic [PIX_W-1:0]  y;
		bit                wait_idle;
	} request_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command       = '0;
	logic [ADDR_W-1:0]    table_address = '0;
	logic [DATA_W-1:0]    table_data    = '0;
	logic [PIX_W-1:0]     pixel_x       = '0;
	logic [PIX_W-1:0]     pixel_y       = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [COLOR_W-1:0]   color;
	logic [REGION_W-1:0]  region;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;

	// Predicted table contents, updated as loads are accepted
	bit [LID_W-1:0]   upper_lid_mem [LID_DEPTH];
	bit [LID_W-1:0]   lower_lid_mem [LID_DEPTH];
	bit [DATA_W-1:0]  sclera_mem    [SCLERA_DEPTH];
	bit [DATA_W-1:0]  polar_mem     [POLAR_DEPTH];
	bit [DATA_W-1:0]  texture_mem   [TEX_DEPTH];

	// Register copies, updated as writes are accepted
	logic [SCALE_W-1:0] iris_scale = RST_IRIS_SCALE;
	logic [OFS_W-1:0]   x_offset   = RST_SCLERA_X;
	logic [OFS_W-1:0]   y_offset   = RST_SCLERA_Y;
	logic [LID_W-1:0]   upper_th   = RST_UPPER_TH;
	logic [LID_W-1:0]   lower_th   = RST_LOWER_TH;

	// Entries already loaded in the stream, so that renders only touch written entries
	bit              upper_written   [LID_DEPTH];
	bit              lower_written   [LID_DEPTH];
	bit              sclera_written  [SCLERA_DEPTH];
	bit              polar_written   [POLAR_DEPTH];
	bit              texture_written [TEX_DEPTH];
	bit [DATA_W-1:0] polar_plan      [POLAR_DEPTH];

	request_t pending_requests [$];
	pixel_t   expected_pixels  [$];
	request_t cur_req;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int queued_items   = 0;
	bit hold_next      = 1'b0;

	eye_pixel_compositor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.table_address (table_address),
		.table_data    (table_data),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.color         (color),
		.region        (region),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abandon a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** eye_pixel_compositor: FAILED **");
			$finish;
		end
	end

	// Present queued requests; apply each accepted transaction to the predicted state
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic            next_valid;
		int              lid, sx, sy, ix, iy, scl, radius, angle;
		logic [DATA_W-1:0] polar;
		pixel_t          want;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				next_valid = 1'b0;
				case (cur_req.command)
					CMD_UPPER_LID: if (cur_req.address < LID_DEPTH)
						upper_lid_mem[cur_req.address] = cur_req.data[LID_W-1:0];
					CMD_LOWER_LID: if (cur_req.address < LID_DEPTH)
						lower_lid_mem[cur_req.address] = cur_req.data[LID_W-1:0];
					CMD_SCLERA: if (cur_req.address < SCLERA_DEPTH)
						sclera_mem[cur_req.address] = cur_req.data;
					CMD_POLAR: if (cur_req.address < POLAR_DEPTH)
						polar_mem[cur_req.address] = cur_req.data;
					CMD_TEXTURE: if (cur_req.address < TEX_DEPTH)
						texture_mem[cur_req.address] = cur_req.data;
					CMD_RENDER: begin
						lid = (int'(cur_req.y) * SCREEN_SIDE + int'(cur_req.x)) % LID_DEPTH;
						sx  = int'(x_offset) + int'(cur_req.x);
						sy  = int'(y_offset) + int'(cur_req.y);
						ix  = sx - IRIS_MARGIN;
						iy  = sy - IRIS_MARGIN;
						scl = (sy % SCLERA_SIDE) * SCLERA_SIDE + sx % SCLERA_SIDE;
						if (lower_lid_mem[lid] <= lower_th || upper_lid_mem[lid] <= upper_th) begin
							want.color  = '0;
							want.region = REGION_LID;
						end else if (iy < 0 || iy >= IRIS_SIDE || ix < 0 || ix >= IRIS_SIDE) begin
							want.color  = sclera_mem[scl];
							want.region = REGION_SCLERA;
						end else begin
							polar  = polar_mem[iy * IRIS_SIDE + ix];
							radius = int'(iris_scale) * int'(polar[DIST_W-1:0]) / (1 << SCALE_SHIFT);
							if (radius < TEXTURE_HEIGHT) begin
								angle = TEXTURE_WIDTH * int'(polar >> DIST_W) / ANGLE_RANGE;
								want.color  = texture_mem[(radius * TEXTURE_WIDTH + angle) % TEX_DEPTH];
								want.region = REGION_IRIS;
							end else begin
								want.color  = sclera_mem[scl];
								want.region = REGION_BEYOND;
							end
						end
						expected_pixels.push_back(want);
					end
					default: ;
				endcase
			end
			// Hold a marked request back until every predicted pixel has come out
			if (!next_valid && pending_requests.size() != 0 &&
			    !(pending_requests[0].wait_idle && expected_pixels.size() != 0) &&
			    $urandom_range(0, 99) >= send_gap_pct) begin
				cur_req = pending_requests.pop_front();
				command       <= cur_req.command;
				table_address <= cur_req.address;
				table_data    <= cur_req.data;
				pixel_x       <= cur_req.x;
				pixel_y       <= cur_req.y;
				next_valid = 1'b1;
			end
			in_valid <= next_valid;
		end
	end

	// Compare each pixel transaction with the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin : check_pixels
		pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected pixel: color %h region %0d", color, region);
				end else begin
					want = expected_pixels.pop_front();
					if (color !== want.color || region !== want.region) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("pixel mismatch: expected color %h region %0d, got color %h region %0d",
								want.color, want.region, color, region);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic int table_depth(input logic [CMD_W-1:0] cmd);
		case (cmd)
			CMD_UPPER_LID, CMD_LOWER_LID: return LID_DEPTH;
			CMD_SCLERA:                   return SCLERA_DEPTH;
			CMD_POLAR:                    return POLAR_DEPTH;
			CMD_TEXTURE:                  return TEX_DEPTH;
			default:                      return 0;
		endcase
	endfunction

	// Lid value, biased above the threshold so that some pixels stay uncovered
	function automatic logic [DATA_W-1:0] lid_word(input logic [LID_W-1:0] th);
		logic [LID_W-1:0] level;
		if (th != '1 && $urandom_range(0, 1))
			level = LID_W'($urandom_range(int'(th) + 1, (1 << LID_W) - 1));
		else
			level = LID_W'($urandom);
		return {LID_W'($urandom), level};
	endfunction

	task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] address,
			input logic [DATA_W-1:0] data, input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		request_t req;
		req.command   = cmd;
		req.address   = address;
		req.data      = data;
		req.x         = x;
		req.y         = y;
		req.wait_idle = hold_next;
		hold_next = 1'b0;
		pending_requests.push_back(req);
		queued_items++;
		// Track which entries the stream has written; ignored requests do not count
		if (cmd <= CMD_TEXTURE && address < table_depth(cmd)) begin
			case (cmd)
				CMD_UPPER_LID: upper_written[address] = 1'b1;
				CMD_LOWER_LID: lower_written[address] = 1'b1;
				CMD_SCLERA:    sclera_written[address] = 1'b1;
				CMD_POLAR: begin
					polar_written[address] = 1'b1;
					polar_plan[address]    = data;
				end
				default:       texture_written[address] = 1'b1;
			endcase
		end
	endtask

	// Load every entry a render of (x, y) may read, refreshing some at random, then render
	task automatic queue_pixel(input int x, input int y);
		int lid, sx, sy, ix, iy, scl, pidx, radius, tidx, dmax;
		logic [DATA_W-1:0] polar;
		lid = y * SCREEN_SIDE + x;
		if (!upper_written[lid] || $urandom_range(0, 3) == 0)
			push_request(CMD_UPPER_LID, ADDR_W'(lid), lid_word(upper_th), PIX_W'($urandom),
				PIX_W'($urandom));
		if (!lower_written[lid] || $urandom_range(0, 3) == 0)
			push_request(CMD_LOWER_LID, ADDR_W'(lid), lid_word(lower_th), PIX_W'($urandom),
				PIX_W'($urandom));
		sx  = int'(x_offset) + x;
		sy  = int'(y_offset) + y;
		scl = (sy % SCLERA_SIDE) * SCLERA_SIDE + sx % SCLERA_SIDE;
		if (!sclera_written[scl] || $urandom_range(0, 3) == 0)
			push_request(CMD_SCLERA, ADDR_W'(scl), DATA_W'($urandom), PIX_W'($urandom),
				PIX_W'($urandom));
		ix = sx - IRIS_MARGIN;
		iy = sy - IRIS_MARGIN;
		if (ix >= 0 && ix < IRIS_SIDE && iy >= 0 && iy < IRIS_SIDE) begin
			pidx = iy * IRIS_SIDE + ix;
			if (!polar_written[pidx] || $urandom_range(0, 3) == 0) begin
				// Favour distances that land inside the texture at the current scale
				dmax = (iris_scale == 0) ? 127 : ((TEXTURE_HEIGHT << SCALE_SHIFT) - 1) / iris_scale;
				if (dmax > 127)
					dmax = 127;
				polar = DATA_W'($urandom);
				polar[DIST_W-1:0] = $urandom_range(0, 1) ? DIST_W'($urandom_range(0, dmax))
					: DIST_W'($urandom);
				push_request(CMD_POLAR, ADDR_W'(pidx), polar, PIX_W'($urandom), PIX_W'($urandom));
			end
			polar  = polar_plan[pidx];
			radius = int'(iris_scale) * int'(polar[DIST_W-1:0]) / (1 << SCALE_SHIFT);
			tidx   = (radius * TEXTURE_WIDTH + TEXTURE_WIDTH * int'(polar >> DIST_W) / ANGLE_RANGE)
				% TEX_DEPTH;
			if (!texture_written[tidx] || $urandom_range(0, 3) == 0)
				push_request(CMD_TEXTURE, ADDR_W'(tidx), DATA_W'($urandom), PIX_W'($urandom),
					PIX_W'($urandom));
		end
		push_request(CMD_RENDER, ADDR_W'($urandom), DATA_W'($urandom), PIX_W'(x), PIX_W'(y));
	endtask

	task automatic wait_until_idle();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; valid stays high for a following write
	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_IRIS_SCALE: iris_scale = value[SCALE_W-1:0];
			CFG_SCLERA_X:   x_offset   = value[OFS_W-1:0];
			CFG_SCLERA_Y:   y_offset   = value[OFS_W-1:0];
			CFG_UPPER_TH:   upper_th   = value[LID_W-1:0];
			CFG_LOWER_TH:   lower_th   = value[LID_W-1:0];
			default: ;
		endcase
	endtask

	// Drain, reprogram every register, then queue a mix of render sequences and noise
	task automatic run_phase(input int send_pct, input int recv_pct,
			input logic [SCALE_W-1:0] scale, input logic [OFS_W-1:0] xoff,
			input logic [OFS_W-1:0] yoff, input logic [LID_W-1:0] uth,
			input logic [LID_W-1:0] lth, input int item_count);
		int               start, pick;
		bit               hold_done;
		logic [CMD_W-1:0] cmd;
		wait_until_idle();
		send_gap_pct   = send_pct;
		recv_stall_pct = recv_pct;
		cfg_beat(CFG_IRIS_SCALE, scale);
		cfg_beat(CFG_SCLERA_X, {(CFG_W-OFS_W)'($urandom), xoff});
		cfg_beat(CFG_SCLERA_Y, {(CFG_W-OFS_W)'($urandom), yoff});
		cfg_beat(CFG_UPPER_TH, {(CFG_W-LID_W)'($urandom), uth});
		cfg_beat(CFG_LOWER_TH, {(CFG_W-LID_W)'($urandom), lth});
		cfg_beat(CFG_SPARE, CFG_W'($urandom));
		cfg_valid <= 1'b0;
		start     = queued_items;
		hold_done = 1'b0;
		while (queued_items - start < item_count) begin
			if (!hold_done && queued_items - start >= item_count / 2) begin
				hold_next = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				queue_pixel($urandom_range(0, 127), $urandom_range(0, 127));
			end else if (pick < 66) begin
				queue_pixel($urandom_range(0, 1) * 127, $urandom_range(0, 1) * 127);
			end else if (pick < 88) begin
				cmd = CMD_W'($urandom_range(CMD_UPPER_LID, CMD_TEXTURE));
				push_request(cmd, ADDR_W'($urandom_range(0, table_depth(cmd) - 1)),
					DATA_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
			end else if (pick < 94) begin
				push_request(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), ADDR_W'($urandom),
					DATA_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
			end else begin
				// Aim a load past the end of a table; the sclera spans every address
				do cmd = CMD_W'($urandom_range(CMD_UPPER_LID, CMD_TEXTURE));
				while (cmd == CMD_SCLERA);
				push_request(cmd, ADDR_W'($urandom_range(table_depth(cmd), (1 << ADDR_W) - 1)),
					DATA_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
			end
		end
	endtask

	initial begin
		send_gap_pct   = 12;
		recv_stall_pct = 63;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values, all on screen pixel (0, 0)
		push_request(CMD_UPPER_LID, 0, 16'hFFFF, '1, '1);
		// one above the lower threshold: uncovered
		push_request(CMD_LOWER_LID, 0, 16'h007F, '0, '0);
		push_request(CMD_SCLERA, ADDR_W'(RST_SCLERA_Y * SCLERA_SIDE + RST_SCLERA_X), 16'hFFFF,
			'0, '1);
		push_request(CMD_SCLERA, '1, 16'h8001, '1, '0);
		// widest angle, distance scaling to just inside the texture
		push_request(CMD_POLAR, 0, 16'hFF8F, '0, '0);
		push_request(CMD_TEXTURE, ADDR_W'(60 * TEXTURE_WIDTH + 511), 16'hA5C3, '0, '0);
		// loads past the end of their tables must leave entry zero alone
		push_request(CMD_UPPER_LID, ADDR_W'(LID_DEPTH), 16'h0000, '0, '0);
		push_request(CMD_LOWER_LID, '1, 16'h0000, '0, '0);
		push_request(CMD_POLAR, '1, 16'h007F, '0, '0);
		push_request(CMD_TEXTURE, ADDR_W'(TEX_DEPTH), 16'h0000, '0, '0);
		push_request(CMD_SPARE_HI, '1, '1, '1, '1);
		push_request(CMD_SPARE_LO, '0, '0, '0, '0);
		push_request(CMD_RENDER, '1, '1, '0, '0);
		// distance scaling to exactly the texture height falls back to the sclera
		push_request(CMD_POLAR, 0, 16'h0010, '0, '0);
		push_request(CMD_TEXTURE, 0, 16'h5A5A, '0, '0);
		push_request(CMD_RENDER, '0, '0, '0, '0);
		// lower lid at its threshold covers the pixel
		push_request(CMD_LOWER_LID, 0, 16'h007E, '0, '0);
		push_request(CMD_RENDER, '0, '1, '0, '0);
		// upper lid at its threshold covers the pixel
		push_request(CMD_LOWER_LID, 0, 16'hFFFF, '0, '0);
		push_request(CMD_UPPER_LID, 0, 16'h0080, '0, '0);
		push_request(CMD_RENDER, '1, '0, '0, '0);

		// Random phases: receiver stalls most, then sender idles most, then no idling
		run_phase(12, 63, 0, 0, 0, 0, 0, 300);
		run_phase(12, 63, 1023, 255, 128, 254, 200, 300);
		run_phase(63, 12, 128, 128, 255, 100, 50, 300);
		run_phase(63, 12, SCALE_W'($urandom), OFS_W'($urandom_range(0, 128)),
			OFS_W'($urandom_range(0, 128)), LID_W'($urandom), LID_W'($urandom), 300);
		run_phase(0, 0, 300, 20, 200, 255, 255, 80);
		run_phase(0, 0, SCALE_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
			LID_W'($urandom), LID_W'($urandom), 320);
		run_phase(0, 0, RST_IRIS_SCALE, RST_SCLERA_X, RST_SCLERA_Y, RST_UPPER_TH, RST_LOWER_TH, 300);

		wait_until_idle();
		if (mismatch_count == 0) begin
			$display("** eye_pixel_compositor: PASSED **");
		end else begin
			$display("** eye_pixel_compositor: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/epc_pkg.sv
rtl/epc_ram.sv
rtl/epc_out_fifo.sv
rtl/eye_pixel_compositor.sv
verif/eye_pixel_compositor_tb.sv
